/* hw/rtl/atc_pkg.sv */
package atc_pkg;

	// Field widths
	localparam int ACC_W = 16;
	localparam int DEG_W = 9;
	localparam int NUM_W = ACC_W + 1;

	// CORDIC configuration
	localparam int CORDIC_STAGES   = 16;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int TAB_FRAC_BITS   = 24;
	localparam int TAB_LEN         = 24;
	localparam int TAB_W           = 30;
	localparam int TAB_IW          = $clog2(TAB_LEN);
	localparam int GUARD_BITS      = 24;
	localparam int N_ROT = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

	// Vector datapath: sign, 18 integer bits of headroom, guard fraction bits
	localparam int DP_W  = 19 + GUARD_BITS;
	// Angle accumulator: sign, 9 integer bits, fraction
	localparam int ANG_W = 10 + ANGLE_FRAC_BITS;
	localparam int WHOLE_W = ANG_W - ANGLE_FRAC_BITS;

	localparam int TAB_SHIFT  = TAB_FRAC_BITS - ANGLE_FRAC_BITS;
	localparam int ROUND_HALF = (TAB_SHIFT > 0) ? (1 << (TAB_SHIFT - 1)) : 0;
	localparam int DEG_MAX    = 180;

	// atan(2^-i) * 57.296 with 24 fraction bits
	localparam logic [TAB_W-1:0] ATAN_Q24 [TAB_LEN] = '{
		30'd754977625, 30'd445689317, 30'd235489995, 30'd119538398,
		30'd60001165,  30'd30029832,  30'd15018580,  30'd7509749,
		30'd3754932,   30'd1877473,   30'd938737,    30'd469369,
		30'd234684,    30'd117342,    30'd58671,     30'd29336,
		30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115
	};

	typedef struct packed {
		logic signed [DP_W-1:0]  x;
		logic signed [DP_W-1:0]  y;
		logic signed [ANG_W-1:0] z;
		logic                    special;
		logic                    half_turn;
	} lane_t;

	typedef struct packed {
		logic  valid;
		lane_t roll;
		lane_t pitch;
	} stage_t;

	function automatic logic signed [ANG_W-1:0] stage_angle(logic [TAB_IW-1:0] i);
		logic [TAB_W:0] t;
		t = {1'b0, ATAN_Q24[i]};
		t = (t + (TAB_W + 1)'(ROUND_HALF)) >> TAB_SHIFT;
		return ANG_W'(t);
	endfunction

	// Quadrant pre-rotation to x >= 0 and scaling into the guard format
	function automatic lane_t pre_rotate(logic signed [NUM_W-1:0] num,
			logic signed [ACC_W-1:0] den);
		lane_t                   l;
		logic signed [DP_W-1:0]  n;
		logic signed [DP_W-1:0]  d;
		logic signed [DP_W-1:0]  xs;
		logic signed [DP_W-1:0]  ys;
		logic signed [ANG_W-1:0] a90;
		n   = DP_W'(num);
		d   = DP_W'(den);
		a90 = stage_angle('0) + stage_angle('0);
		if (d < 0) begin
			if (n >= 0) begin
				xs  = n;
				ys  = -d;
				l.z = a90;
			end else begin
				xs  = -n;
				ys  = d;
				l.z = -a90;
			end
		end else begin
			xs  = d;
			ys  = n;
			l.z = '0;
		end
		l.x         = xs <<< GUARD_BITS;
		l.y         = ys <<< GUARD_BITS;
		l.special   = (num == 0) && (den <= 0);
		l.half_turn = (den < 0);
		return l;
	endfunction

	// One vectoring micro-rotation
	function automatic lane_t rotate(lane_t l, logic [TAB_IW-1:0] i);
		lane_t r;
		r = l;
		if (l.y >= 0) begin
			r.x = l.x + (l.y >>> i);
			r.y = l.y - (l.x >>> i);
			r.z = l.z + stage_angle(i);
		end else begin
			r.x = l.x - (l.y >>> i);
			r.y = l.y + (l.x >>> i);
			r.z = l.z - stage_angle(i);
		end
		return r;
	endfunction

	// Truncate toward zero to whole degrees, clamp, apply the axis cases
	function automatic logic signed [DEG_W-1:0] to_degrees(lane_t l);
		logic [ANG_W-1:0]   mag;
		logic [WHOLE_W-1:0] whole;
		logic [DEG_W-1:0]   m;
		logic signed [DEG_W-1:0] res;
		mag   = l.z[ANG_W-1] ? ANG_W'(-l.z) : ANG_W'(l.z);
		whole = mag[ANG_W-1:ANGLE_FRAC_BITS];
		if (whole > WHOLE_W'(DEG_MAX)) begin
			m = DEG_W'(DEG_MAX);
		end else begin
			m = DEG_W'(whole);
		end
		res = l.z[ANG_W-1] ? -$signed(m) : $signed(m);
		if (l.special) begin
			res = l.half_turn ? DEG_W'(DEG_MAX) : '0;
		end
		return res;
	endfunction

endpackage

/* hw/rtl/atc_if.sv */
interface atc_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [atc_pkg::ACC_W-1:0]  accel_x;
	logic signed [atc_pkg::ACC_W-1:0]  accel_y;
	logic signed [atc_pkg::ACC_W-1:0]  accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z,
		input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z,
		output ready);
endinterface

interface atc_angle_if;
	logic                              valid;
	logic                              ready;
	logic signed [atc_pkg::DEG_W-1:0]  roll_degrees;
	logic signed [atc_pkg::DEG_W-1:0]  pitch_degrees;

	modport source (output valid, output roll_degrees, output pitch_degrees,
		input ready);
	modport sink (input valid, input roll_degrees, input pitch_degrees,
		output ready);
endinterface

/* hw/rtl/atc_prerot.sv */
module atc_prerot (
	input  logic             clk,
	input  logic             arst_n,
	atc_sample_if.sink       sample,
	input  logic             dn_ready,
	output atc_pkg::stage_t  pre_s1
);

	logic load;

	assign sample.ready = !pre_s1.valid || dn_ready;
	assign load         = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_s1 <= '0;
		end else begin
			if (sample.ready) begin
				pre_s1.valid <= sample.valid;
			end
			if (load) begin
				pre_s1.roll  <= atc_pkg::pre_rotate(atc_pkg::NUM_W'(sample.accel_y),
					sample.accel_z);
				pre_s1.pitch <= atc_pkg::pre_rotate(-atc_pkg::NUM_W'(sample.accel_x),
					sample.accel_z);
			end
		end
	end

	a_roll_right_half: assert property (@(posedge clk) disable iff (!arst_n)
		pre_s1.valid && !pre_s1.roll.special |-> pre_s1.roll.x >= 0)
		else $error("roll vector left of the y axis after pre-rotation");

	a_pitch_right_half: assert property (@(posedge clk) disable iff (!arst_n)
		pre_s1.valid && !pre_s1.pitch.special |-> pre_s1.pitch.x >= 0)
		else $error("pitch vector left of the y axis after pre-rotation");

endmodule

/* hw/rtl/atc_cordic.sv */
module atc_cordic (
	input  logic             clk,
	input  logic             arst_n,
	input  atc_pkg::stage_t  up,
	output logic             up_ready,
	input  logic             dn_ready,
	output atc_pkg::stage_t  dn
);

	atc_pkg::stage_t           rot_s2 [atc_pkg::N_ROT];
	logic [atc_pkg::N_ROT:0]   rdy;

	assign rdy[atc_pkg::N_ROT] = dn_ready;
	assign up_ready            = rdy[0];
	assign dn                  = rot_s2[atc_pkg::N_ROT-1];

	for (genvar k = 0; k < atc_pkg::N_ROT; k++) begin : g_rot
		atc_pkg::stage_t src;

		if (k == 0) begin : g_first
			assign src = up;
		end else begin : g_next
			assign src = rot_s2[k-1];
		end

		// a stage takes new data when empty or when its successor moves
		assign rdy[k] = !rot_s2[k].valid || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_s2[k] <= '0;
			end else begin
				if (rdy[k]) begin
					rot_s2[k].valid <= src.valid;
				end
				if (rdy[k] && src.valid) begin
					rot_s2[k].roll  <= atc_pkg::rotate(src.roll, atc_pkg::TAB_IW'(k));
					rot_s2[k].pitch <= atc_pkg::rotate(src.pitch, atc_pkg::TAB_IW'(k));
				end
			end
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		dn.valid && !dn_ready |=> dn.valid && $stable(dn.roll) && $stable(dn.pitch))
		else $error("last rotation stage changed while stalled");

endmodule

/* hw/rtl/atc_post.sv */
module atc_post (
	input  logic             clk,
	input  logic             arst_n,
	input  atc_pkg::stage_t  up,
	output logic             up_ready,
	atc_angle_if.source      angles
);

	logic                             valid_s3;
	logic signed [atc_pkg::DEG_W-1:0] roll_s3;
	logic signed [atc_pkg::DEG_W-1:0] pitch_s3;

	assign up_ready             = !valid_s3 || angles.ready;
	assign angles.valid         = valid_s3;
	assign angles.roll_degrees  = roll_s3;
	assign angles.pitch_degrees = pitch_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up.valid) begin
			roll_s3  <= atc_pkg::to_degrees(up.roll);
			pitch_s3 <= atc_pkg::to_degrees(up.pitch);
		end
	end

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> roll_s3 >= -atc_pkg::DEG_MAX && roll_s3 <= atc_pkg::DEG_MAX)
		else $error("roll angle out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> pitch_s3 >= -atc_pkg::DEG_MAX && pitch_s3 <= atc_pkg::DEG_MAX)
		else $error("pitch angle out of range");

endmodule

/* hw/rtl/accel_tilt_angles.sv */
// Tilt angles from a three-axis accelerometer sample. Each request on the
// sample channel carries raw signed 16-bit x, y and z readings and produces
// exactly one request on the angles channel with roll = atan2(y, z) and
// pitch = atan2(-x, z), in whole degrees truncated toward zero and limited
// to -180..180. A zero vector reads as 0 and a zero numerator with negative
// z as +180. Samples are independent and the block keeps no state between
// them, so it takes one sample every clock cycle unless the angles channel
// stalls. The pipeline has one register for the quadrant pre-rotation,
// one register per CORDIC micro-rotation, and one output register for
// truncation and clamping. Every stage holds its own valid bit and moves
// on when empty or when the stage after it moves, so a stall on the angles
// channel fills bubbles first and then pushes back on the sample channel
// without dropping or repeating a request.
module accel_tilt_angles (
	input  logic         clk,
	input  logic         arst_n,
	atc_sample_if.sink   sample,
	atc_angle_if.source  angles
);

	// Stage 1: pre-rotate both vectors into the right half plane
	atc_pkg::stage_t pre_s1;
	logic            rot_ready;

	// Stage 2: unrolled micro-rotations, one register each
	atc_pkg::stage_t rot_last;
	logic            post_ready;

	atc_prerot u_prerot (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.dn_ready (rot_ready),
		.pre_s1   (pre_s1)
	);

	atc_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.up       (pre_s1),
		.up_ready (rot_ready),
		.dn_ready (post_ready),
		.dn       (rot_last)
	);

	// Stage 3: truncate to whole degrees, clamp, present the result
	atc_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.up       (rot_last),
		.up_ready (post_ready),
		.angles   (angles)
	);

	// with nothing waiting at the output every stage can advance
	a_open_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!angles.valid |-> sample.ready)
		else $error("sample channel blocked with an empty output");

endmodule
